[rtl/clmd_pkg.sv]
// Shared types, character codes and the header-name table for the
// content-length message deframer. No dependencies.
`default_nettype none
package clmd_pkg;

    // Width of the content length and body counter
    localparam int LEN_WIDTH = 24;

    // Character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Header name length ("content-length")
    localparam logic [3:0] NAME_LEN = 4'd14;

    // Terminator progress codes (CR LF CR LF)
    localparam logic [2:0] TP_NONE = 3'd0;
    localparam logic [2:0] TP_CR1  = 3'd1;
    localparam logic [2:0] TP_LF1  = 3'd2;
    localparam logic [2:0] TP_CR2  = 3'd3;
    localparam logic [2:0] TP_DONE = 3'd4;

    // Skip counter codes: two skipped bytes, then value open, then closed
    localparam logic [1:0] SKIP_OPEN   = 2'd2;
    localparam logic [1:0] SKIP_CLOSED = 2'd3;

    // Running parse state
    typedef struct packed {
        logic                 body;
        logic [2:0]           term;
        logic [3:0]           name_prog;
        logic                 found;
        logic [1:0]           skip;
        logic [LEN_WIDTH-1:0] acc;
        logic                 invalid;
        logic                 digit;
        logic                 minus;
        logic [LEN_WIDTH-1:0] rem;
    } t_state;

    // Per-word markers
    typedef struct packed {
        logic in_body;
        logic message_end;
        logic length_error;
    } t_res;

    // Lower-case header name, one character per index
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/clmd_in_if.sv]
// Input stream channel: valid/ready handshake carrying one received byte.
// Depends on nothing.
`default_nettype none
interface clmd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface
`default_nettype wire

[rtl/clmd_out_if.sv]
// Output channel: echoed byte with header/body and framing markers.
// Depends on nothing.
`default_nettype none
interface clmd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] echo_byte;
    logic       in_body;
    logic       message_end;
    logic       length_error;

    modport source (output valid, output echo_byte, output in_body,
                    output message_end, output length_error, input ready);
    modport sink   (input valid, input echo_byte, input in_body,
                    input message_end, input length_error, output ready);
endinterface
`default_nettype wire

[rtl/clmd_track.sv]
// Next-state logic of the deframer: name match, value parse, terminator
// detect and body count for one byte. Depends on clmd_pkg.
`default_nettype none
module clmd_track (
    input  wire clmd_pkg::t_state i_state,
    input  wire logic [7:0]       i_byte,
    output clmd_pkg::t_state      o_state,
    output clmd_pkg::t_res        o_res
);

    clmd_pkg::t_state                 n;
    clmd_pkg::t_res                   res;
    logic [7:0]                       lc;
    logic [3:0]                       p;
    logic [clmd_pkg::LEN_WIDTH+3:0]   acc_next;
    logic [clmd_pkg::LEN_WIDTH-1:0]   len;
    logic                             good;

    // Times ten plus digit, with four guard bits for overflow
    assign acc_next = {1'b0, i_state.acc, 3'b000}
                    + {3'b000, i_state.acc, 1'b0}
                    + {{clmd_pkg::LEN_WIDTH{1'b0}}, i_byte[3:0]};

    always_comb begin
        n    = i_state;
        res  = '0;
        p    = i_state.name_prog;
        len  = '0;
        good = 1'b0;
        lc   = (i_byte inside {[clmd_pkg::CH_UC_A:clmd_pkg::CH_UC_Z]})
             ? i_byte + clmd_pkg::CASE_OFS : i_byte;

        if (i_state.body) begin
            // Body: count down, last word closes the message
            res.in_body = 1'b1;
            if (i_state.rem <= clmd_pkg::LEN_WIDTH'(1)) begin
                res.message_end = 1'b1;
                n = '0;
            end else begin
                n.rem = i_state.rem - clmd_pkg::LEN_WIDTH'(1);
            end
        end else begin
            if (i_state.found) begin
                // Skip two bytes, then parse the value up to CR
                if (i_state.skip < clmd_pkg::SKIP_OPEN) begin
                    n.skip = i_state.skip + 2'd1;
                end else if (i_state.skip == clmd_pkg::SKIP_OPEN) begin
                    if (i_byte == clmd_pkg::CH_CR) begin
                        n.skip = clmd_pkg::SKIP_CLOSED;
                    end else if (i_byte == clmd_pkg::CH_SP) begin
                        n.skip = i_state.skip;
                    end else if (i_byte == clmd_pkg::CH_PLUS ||
                                 i_byte == clmd_pkg::CH_MINUS) begin
                        if (i_state.digit || i_state.minus) begin
                            n.invalid = 1'b1;
                        end else if (i_byte == clmd_pkg::CH_MINUS) begin
                            n.minus = 1'b1;
                        end
                    end else if (i_byte inside {[clmd_pkg::CH_0:clmd_pkg::CH_9]}) begin
                        n.digit = 1'b1;
                        if (!i_state.invalid) begin
                            if (acc_next[clmd_pkg::LEN_WIDTH+3:clmd_pkg::LEN_WIDTH] != 4'd0)
                                n.invalid = 1'b1;
                            else
                                n.acc = acc_next[clmd_pkg::LEN_WIDTH-1:0];
                        end
                    end else begin
                        n.invalid = 1'b1;
                    end
                end
            end else begin
                // Case-insensitive search for the header name
                if (i_state.name_prog < clmd_pkg::NAME_LEN &&
                    lc == clmd_pkg::name_char(i_state.name_prog))
                    p = i_state.name_prog + 4'd1;
                else
                    p = (lc == clmd_pkg::CH_LC_C) ? 4'd1 : 4'd0;
                if (p >= clmd_pkg::NAME_LEN) begin
                    n.found = 1'b1;
                    n.skip  = 2'd0;
                    p       = 4'd0;
                end
                n.name_prog = p;
            end

            // Header terminator tracking
            case (i_state.term)
                clmd_pkg::TP_NONE:
                    n.term = (i_byte == clmd_pkg::CH_CR) ? clmd_pkg::TP_CR1
                                                         : clmd_pkg::TP_NONE;
                clmd_pkg::TP_CR1:
                    n.term = (i_byte == clmd_pkg::CH_LF) ? clmd_pkg::TP_LF1 :
                             (i_byte == clmd_pkg::CH_CR) ? clmd_pkg::TP_CR1 :
                                                           clmd_pkg::TP_NONE;
                clmd_pkg::TP_LF1:
                    n.term = (i_byte == clmd_pkg::CH_CR) ? clmd_pkg::TP_CR2
                                                         : clmd_pkg::TP_NONE;
                clmd_pkg::TP_CR2:
                    n.term = (i_byte == clmd_pkg::CH_LF) ? clmd_pkg::TP_DONE :
                             (i_byte == clmd_pkg::CH_CR) ? clmd_pkg::TP_CR1 :
                                                           clmd_pkg::TP_NONE;
                default:
                    n.term = (i_byte == clmd_pkg::CH_CR) ? clmd_pkg::TP_CR1
                                                         : clmd_pkg::TP_NONE;
            endcase

            // End of header: pick body length, end an empty message, or flag the error
            if (n.term == clmd_pkg::TP_DONE) begin
                good = n.found && n.digit && !n.invalid;
                len  = good ? n.acc : '0;
                if (good && n.minus && len != '0) begin
                    res.length_error = 1'b1;
                    n = '0;
                end else if (len == '0) begin
                    res.message_end = 1'b1;
                    n = '0;
                end else begin
                    n      = '0;
                    n.body = 1'b1;
                    n.rem  = len;
                end
            end
        end
    end

    assign o_state = n;
    assign o_res   = res;

endmodule
`default_nettype wire

[rtl/content_length_message_deframer.sv]
// Content-length message deframer, top level (clmd_pkg, clmd_in_if, clmd_out_if, clmd_track).
// Each byte passes through the input register, then the result register;
// throughput 1 word per cycle when the output does not stall, as clmd_track parses
// each byte combinationally. Output stalls back up through the input register.
// Reset (synchronous, active low) clears the parse state to header phase and
// empties both pipeline registers.
`default_nettype none
module content_length_message_deframer (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    clmd_in_if.sink     i_in,
    clmd_out_if.source  o_out
);

    logic             r_s1_valid;
    logic [7:0]       r_s1_byte;
    logic             r_o_valid;
    logic [7:0]       r_o_byte;
    clmd_pkg::t_res   r_o_res;
    clmd_pkg::t_state r_state;
    clmd_pkg::t_state n_state;
    clmd_pkg::t_res   n_res;
    logic             out_adv;
    logic             s1_adv;

    // Pipeline flow control
    assign out_adv    = !r_o_valid || o_out.ready;
    assign s1_adv     = r_s1_valid && out_adv;
    assign i_in.ready = !r_s1_valid || out_adv;

    clmd_track u_track (
        .i_state (r_state),
        .i_byte  (r_s1_byte),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_s1_byte <= i_in.stream_byte;
        end
    end

    // Parse state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= '0;
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_state   <= n_state;
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
        if (s1_adv) begin
            r_o_byte <= r_s1_byte;
            r_o_res  <= n_res;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.echo_byte    = r_o_byte;
    assign o_out.in_body      = r_o_res.in_body;
    assign o_out.message_end  = r_o_res.message_end;
    assign o_out.length_error = r_o_res.length_error;

`ifndef SYNTHESIS
    // Error and message end are exclusive
    a_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.message_end && o_out.length_error))
        else $error("length_error and message_end both set");

    // Error only on the final LF of a header
    a_err_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.length_error) |->
            (!o_out.in_body && o_out.echo_byte == clmd_pkg::CH_LF))
        else $error("length_error outside header terminator");

    // Body phase always has words left and clean header state
    a_body_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.body |-> (r_state.rem != '0 && !r_state.found &&
                          r_state.term == clmd_pkg::TP_NONE))
        else $error("inconsistent body state");

    // A word leaving the input register shows up at the output
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_o_valid)
        else $error("advanced word lost");
`endif

endmodule
`default_nettype wire
